/* design/dtp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants for the date/time text parser
// Character codes, token classes, parse state codes, the token word that the
// front passes to the back, and the result word.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // Saturation width of the field accumulators
  localparam int FIELD_WIDTH = 16;
  localparam int ACC_W       = (FIELD_WIDTH > 16) ? FIELD_WIDTH : 16;
  localparam logic [ACC_W-1:0] FIELD_MAX =
    ACC_W'((33'd1 << FIELD_WIDTH) - 33'd1);

  // Fixed field widths
  localparam int VAL_W  = 16;
  localparam int ZONE_W = 8;
  localparam int BYTE_W = 8;
  localparam int CIDX_W = 3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_YEAR   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MONTH  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DAY    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HOUR   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MINUTE = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_SECOND = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_ZONE   = 3'd6;

  // Parse states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_YEAR   = 4'd1;
  localparam logic [ST_W-1:0] ST_MONTH  = 4'd2;
  localparam logic [ST_W-1:0] ST_DAY    = 4'd3;
  localparam logic [ST_W-1:0] ST_HOUR   = 4'd4;
  localparam logic [ST_W-1:0] ST_MINUTE = 4'd5;
  localparam logic [ST_W-1:0] ST_SECOND = 4'd6;
  localparam logic [ST_W-1:0] ST_END    = 4'd7;
  localparam logic [ST_W-1:0] ST_ERROR  = 4'd8;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_UT    = 8'h54;
  localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;

  // Token classes
  typedef enum logic [3:0] {
    CL_NUL,
    CL_DIGIT,
    CL_DASH,
    CL_COLON,
    CL_BLANK,   // the space character: whitespace and separator
    CL_WS,      // tab, LF, VT, FF, CR
    CL_SEP,     // T, t, comma
    CL_ZONE,
    CL_OTHER
  } cls_e;

  // Token word from front to back
  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic       zone_up;
  } tok_t;

  // Configuration write
  typedef struct packed {
    logic              valid;
    logic [CIDX_W-1:0] index;
    logic [VAL_W-1:0]  data;
  } cfg_t;

  // Result word
  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  year;
    logic [VAL_W-1:0]  month;
    logic [VAL_W-1:0]  day;
    logic [VAL_W-1:0]  hour;
    logic [VAL_W-1:0]  minute;
    logic [VAL_W-1:0]  second;
    logic [ZONE_W-1:0] zone;
  } res_t;

  // Sort one byte into its token class
  function automatic tok_t classify(logic [BYTE_W-1:0] c);
    tok_t t;
    t.digit   = 4'(c - CH_ZERO);
    t.zone_up = (c == CH_UZ);
    if (c == CH_NUL)                          t.cls = CL_NUL;
    else if (c >= CH_ZERO && c <= CH_NINE)    t.cls = CL_DIGIT;
    else if (c == CH_DASH)                    t.cls = CL_DASH;
    else if (c == CH_COLON)                   t.cls = CL_COLON;
    else if (c == CH_SPACE)                   t.cls = CL_BLANK;
    else if (c >= CH_TAB && c <= CH_CR)       t.cls = CL_WS;
    else if (c == CH_UT || c == CH_LT || c == CH_COMMA) t.cls = CL_SEP;
    else if (c == CH_UZ || c == CH_LZ)        t.cls = CL_ZONE;
    else                                      t.cls = CL_OTHER;
    return t;
  endfunction

  // Decimal accumulate with saturation at FIELD_MAX
  function automatic logic [ACC_W-1:0] acc_digit(logic [ACC_W-1:0] acc, logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ACC_W{1'b0}}, d};
    if (acc > FIELD_MAX || v > {4'b0, FIELD_MAX}) return FIELD_MAX;
    return v[ACC_W-1:0];
  endfunction

endpackage

/* design/dtp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_front: byte intake and classification
// Classifies each accepted byte and holds the token word in a two-entry
// queue that decouples intake from the parser.
// ----------------------------------------------------------------------------
module dtp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [dtp_pkg::BYTE_W-1:0]  text_byte_i,
  output logic                        tok_valid_o,
  input  logic                        tok_ready_i,
  output dtp_pkg::tok_t               tok_o
);
  import dtp_pkg::*;

  tok_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  // Handshake on both sides
  assign full        = (cnt_q == 2'd2);
  assign wr_en       = push && !full;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign rd_en       = tok_valid_o && tok_ready_i;
  assign tok_o       = mem_q[rd_ptr_q];

  // Store the classified word
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= classify(text_byte_i);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("token queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("token queue pointers disagree with count");
  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !rd_en) |=> full)
    else $error("token queue lost a word while full");
`endif

endmodule

/* design/dtp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_back: parse state machine and result queue
// Holds the default registers, queues a result word for every terminator and
// runs the field accumulators one token word per cycle while not stalled.
// ----------------------------------------------------------------------------
module dtp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtp_pkg::cfg_t  cfg_i,
  input  logic           tok_valid_i,
  output logic           tok_ready_o,
  input  dtp_pkg::tok_t  tok_i,
  output logic           empty,
  input  logic           pop,
  output dtp_pkg::res_t  res_o
);
  import dtp_pkg::*;

  // Default registers
  logic [VAL_W-1:0]  def_year_q, def_month_q, def_day_q;
  logic [VAL_W-1:0]  def_hour_q, def_minute_q, def_second_q;
  logic [ZONE_W-1:0] def_zone_q;

  // Parser state
  logic [ST_W-1:0]   state_q, state_d;
  logic [ACC_W-1:0]  year_q, month_q, day_q, hour_q, minute_q, second_q;
  logic [ACC_W-1:0]  year_d, month_d, day_d, hour_d, minute_d, second_d;
  logic [ZONE_W-1:0] zone_q, zone_d;
  logic [ACC_W-1:0]  def_year_w;
  logic [ZONE_W-1:0] zone_ch;
  logic              idle, step, term, ok;
  res_t              res_d;

  // Result queue
  res_t       rq_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_full, rq_push, rq_pop;

  // Load defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_year_q   <= '0;
      def_month_q  <= '0;
      def_day_q    <= '0;
      def_hour_q   <= '0;
      def_minute_q <= '0;
      def_second_q <= '0;
      def_zone_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_YEAR:   def_year_q   <= cfg_i.data;
        CFG_MONTH:  def_month_q  <= cfg_i.data;
        CFG_DAY:    def_day_q    <= cfg_i.data;
        CFG_HOUR:   def_hour_q   <= cfg_i.data;
        CFG_MINUTE: def_minute_q <= cfg_i.data;
        CFG_SECOND: def_second_q <= cfg_i.data;
        CFG_ZONE:   def_zone_q   <= cfg_i.data[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a word unless it is a terminator and the result queue is full
  assign rq_full     = (rq_cnt_q == 2'd2);
  assign term        = (tok_i.cls == CL_NUL);
  assign tok_ready_o = !(term && rq_full);
  assign step        = tok_valid_i && tok_ready_o;
  assign idle        = (state_q == ST_IDLE);
  assign def_year_w  = ACC_W'(def_year_q);
  assign zone_ch     = tok_i.zone_up ? CH_UZ : CH_LZ;

  // Next state and accumulators; idle fields read as the defaults
  always_comb begin
    year_d   = idle ? ACC_W'(def_year_q)   : year_q;
    month_d  = idle ? ACC_W'(def_month_q)  : month_q;
    day_d    = idle ? ACC_W'(def_day_q)    : day_q;
    hour_d   = idle ? ACC_W'(def_hour_q)   : hour_q;
    minute_d = idle ? ACC_W'(def_minute_q) : minute_q;
    second_d = idle ? ACC_W'(def_second_q) : second_q;
    zone_d   = idle ? def_zone_q           : zone_q;
    state_d  = state_q;
    ok       = 1'b0;
    res_d    = '0;

    if (term) begin
      // Close the string: short date moves, failure reports defaults
      if (state_q == ST_MONTH) begin
        day_d   = month_d;
        month_d = year_d;
        year_d  = def_year_w;
        ok      = 1'b1;
      end else if (state_q >= ST_DAY && state_q <= ST_END) begin
        ok = 1'b1;
      end
      res_d.ok = ok;
      if (ok) begin
        res_d.year   = VAL_W'(year_d);
        res_d.month  = VAL_W'(month_d);
        res_d.day    = VAL_W'(day_d);
        res_d.hour   = VAL_W'(hour_d);
        res_d.minute = VAL_W'(minute_d);
        res_d.second = VAL_W'(second_d);
        res_d.zone   = zone_d;
      end else begin
        res_d.year   = def_year_q;
        res_d.month  = def_month_q;
        res_d.day    = def_day_q;
        res_d.hour   = def_hour_q;
        res_d.minute = def_minute_q;
        res_d.second = def_second_q;
        res_d.zone   = def_zone_q;
      end
      state_d = ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (tok_i.cls == CL_BLANK || tok_i.cls == CL_WS) begin
            state_d = ST_IDLE;
          end else if (tok_i.cls == CL_DIGIT) begin
            year_d  = ACC_W'(tok_i.digit);
            state_d = ST_YEAR;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_YEAR: begin
          if (tok_i.cls == CL_DIGIT) begin
            year_d = acc_digit(year_d, tok_i.digit);
          end else if (tok_i.cls == CL_DASH) begin
            month_d = '0;
            state_d = ST_MONTH;
          end else if (tok_i.cls == CL_COLON) begin
            // Short time form: the first number was the hour
            hour_d   = year_d;
            year_d   = def_year_w;
            minute_d = '0;
            second_d = '0;
            state_d  = ST_MINUTE;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_MONTH: begin
          if (tok_i.cls == CL_DIGIT) begin
            month_d = acc_digit(month_d, tok_i.digit);
          end else if (tok_i.cls == CL_DASH) begin
            day_d   = '0;
            state_d = ST_DAY;
          end else if (tok_i.cls == CL_SEP || tok_i.cls == CL_BLANK) begin
            // Short date form before a time part
            day_d    = month_d;
            month_d  = year_d;
            year_d   = def_year_w;
            hour_d   = '0;
            minute_d = '0;
            second_d = '0;
            state_d  = ST_HOUR;
          end else if (tok_i.cls == CL_ZONE) begin
            zone_d  = zone_ch;
            day_d   = month_d;
            month_d = year_d;
            year_d  = def_year_w;
            state_d = ST_END;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_DAY: begin
          if (tok_i.cls == CL_DIGIT) begin
            day_d = acc_digit(day_d, tok_i.digit);
          end else if (tok_i.cls == CL_SEP || tok_i.cls == CL_BLANK) begin
            hour_d   = '0;
            minute_d = '0;
            second_d = '0;
            state_d  = ST_HOUR;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_HOUR: begin
          if (tok_i.cls == CL_DIGIT) begin
            hour_d = acc_digit(hour_d, tok_i.digit);
          end else if (tok_i.cls == CL_COLON) begin
            state_d = ST_MINUTE;
          end else if (tok_i.cls == CL_ZONE) begin
            zone_d  = zone_ch;
            state_d = ST_END;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_MINUTE: begin
          if (tok_i.cls == CL_DIGIT) begin
            minute_d = acc_digit(minute_d, tok_i.digit);
          end else if (tok_i.cls == CL_COLON) begin
            state_d = ST_SECOND;
          end else if (tok_i.cls == CL_ZONE) begin
            zone_d  = zone_ch;
            state_d = ST_END;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_SECOND: begin
          if (tok_i.cls == CL_DIGIT) begin
            second_d = acc_digit(second_d, tok_i.digit);
          end else if (tok_i.cls == CL_ZONE) begin
            zone_d  = zone_ch;
            state_d = ST_END;
          end else begin
            state_d = ST_ERROR;
          end
        end
        ST_END: begin
          // Ignore everything up to the terminator
          state_d = ST_END;
        end
        default: begin
          state_d = ST_ERROR;
        end
      endcase
    end
  end

  // Hold the accumulators between words
  always_ff @(posedge clk_i) begin
    if (step) begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      zone_q   <= zone_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else if (step) begin
      state_q <= state_d;
    end
  end

  // Queue result words
  assign rq_push = step && term;
  assign empty   = (rq_cnt_q == 2'd0);
  assign rq_pop  = pop && !empty;
  assign res_o   = rq_q[rq_rd_q];

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_q[rq_wr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (rq_push) rq_wr_q <= ~rq_wr_q;
      if (rq_pop)  rq_rd_q <= ~rq_rd_q;
      rq_cnt_q <= rq_cnt_q + {1'b0, rq_push} - {1'b0, rq_pop};
    end
  end

`ifndef SYNTHESIS
  a_term_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && term) |=> (state_q == ST_IDLE))
    else $error("parser not idle after terminator");
  a_end_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !term && state_q == ST_END) |=>
      ($stable(year_q) && $stable(hour_q) && $stable(zone_q) && state_q == ST_END))
    else $error("fields changed after zone letter");
  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= 2'd2) else $error("result queue count out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rq_full && !rq_pop) |=> (rq_cnt_q == 2'd2))
    else $error("result queue overrun");
`endif

endmodule

/* design/iso_date_time_text_parser_top.sv */
`timescale 1ns / 1ps
// Path: an accepted terminator byte is written into the front token queue,
// and the back parser then writes its result word into the result queue.
// Throughput: one byte per cycle while full is low, set by the single
// accumulate step per cycle in the back parser; two-entry queues flank it.
// Reset: queues empty, parser idle, all default registers cleared to zero.
// ----------------------------------------------------------------------------
// iso_date_time_text_parser_top: ISO-8601 style date/time text parser
// Front classifies bytes into token words, back runs the field state machine
// and returns one result word per zero-terminated string.
// ----------------------------------------------------------------------------
module iso_date_time_text_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Byte intake
  input  logic                        push,
  output logic                        full,
  input  logic [dtp_pkg::BYTE_W-1:0]  text_byte_i,
  // Result side
  output logic                        empty,
  input  logic                        pop,
  output logic                        ok_o,
  output logic [dtp_pkg::VAL_W-1:0]   year_o,
  output logic [dtp_pkg::VAL_W-1:0]   month_o,
  output logic [dtp_pkg::VAL_W-1:0]   day_o,
  output logic [dtp_pkg::VAL_W-1:0]   hour_o,
  output logic [dtp_pkg::VAL_W-1:0]   minute_o,
  output logic [dtp_pkg::VAL_W-1:0]   second_o,
  output logic [dtp_pkg::ZONE_W-1:0]  zone_char_o,
  // Configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dtp_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [dtp_pkg::VAL_W-1:0]   cfg_data_i
);
  import dtp_pkg::*;

  tok_t tok;
  logic tok_valid, tok_ready;
  cfg_t cfg;
  res_t res;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;
  assign cfg         = '{valid: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};

  dtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .tok_valid_o (tok_valid),
    .tok_ready_i (tok_ready),
    .tok_o       (tok)
  );

  dtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .tok_valid_i (tok_valid),
    .tok_ready_o (tok_ready),
    .tok_i       (tok),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  // Unpack the result word
  assign ok_o        = res.ok;
  assign year_o      = res.year;
  assign month_o     = res.month;
  assign day_o       = res.day;
  assign hour_o      = res.hour;
  assign minute_o    = res.minute;
  assign second_o    = res.second;
  assign zone_char_o = res.zone;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for iso_date_time_text_parser_top
// Streams text bytes through the queue-style intake and predicts each result
// word with a cycle-free parser model kept in the bench. Results are popped
// under random back pressure and compared field by field in arrival order.
// Default registers are rewritten between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb;
  import dtp_pkg::*;

  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 20;
  localparam int          MAX_REPORTS   = 10;
  localparam int          SEG_BYTES     = 85;
  localparam logic [31:0] SAT_MAX       = 32'((64'd1 << FIELD_WIDTH) - 64'd1);

  // Whitespace codes between tab and carriage return
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;

  typedef enum logic [1:0] {IM_RX_SLOW, IM_TX_SLOW, IM_FREE} idle_mode_e;
  typedef enum logic [2:0] {F_BYTE, F_CFG, F_DRAIN, F_MODE, F_RXHOLD} feed_kind_e;

  typedef struct {
    feed_kind_e        kind;
    logic [BYTE_W-1:0] chr;
    logic [CIDX_W-1:0] idx;
    logic [VAL_W-1:0]  val;
    idle_mode_e        mode;
  } feed_t;

  // DUT connections
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [BYTE_W-1:0]    text_byte_i = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic                 ok_o;
  logic [VAL_W-1:0]     year_o, month_o, day_o, hour_o, minute_o, second_o;
  logic [ZONE_W-1:0]    zone_char_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CIDX_W-1:0]    cfg_index_i = '0;
  logic [VAL_W-1:0]     cfg_data_i  = '0;

  // Bench control
  feed_t                char_feed_q[$];
  res_t                 stamp_q[$];
  logic [BYTE_W-1:0]    draft_q[$];
  idle_mode_e           mode       = IM_RX_SLOW;
  logic                 hold_req   = 1'b0;
  logic                 hold_seen  = 1'b0;
  int                   hold_cnt   = 0;
  int                   quiet_cnt  = 0;
  int                   fail_cnt   = 0;

  // Parser model state
  logic [VAL_W-1:0]     dflt_year = '0, dflt_month = '0, dflt_day = '0;
  logic [VAL_W-1:0]     dflt_hour = '0, dflt_minute = '0, dflt_second = '0;
  logic [ZONE_W-1:0]    dflt_zone = '0;
  logic [ST_W-1:0]      pstate    = ST_IDLE;
  logic [31:0]          acc_year = '0, acc_month = '0, acc_day = '0;
  logic [31:0]          acc_hour = '0, acc_minute = '0, acc_second = '0;
  logic [ZONE_W-1:0]    acc_zone = '0;

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  iso_date_time_text_parser_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .empty       (empty),
    .pop         (pop),
    .ok_o        (ok_o),
    .year_o      (year_o),
    .month_o     (month_o),
    .day_o       (day_o),
    .hour_o      (hour_o),
    .minute_o    (minute_o),
    .second_o    (second_o),
    .zone_char_o (zone_char_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic int tx_idle_pct(idle_mode_e m);
    case (m)
      IM_RX_SLOW: return 34;
      IM_TX_SLOW: return 68;
      default:    return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(idle_mode_e m);
    case (m)
      IM_RX_SLOW: return 68;
      IM_TX_SLOW: return 34;
      default:    return 0;
    endcase
  endfunction

  // Decimal step that pins at the field maximum
  function automatic logic [31:0] dec_step(logic [31:0] acc, logic [3:0] d);
    logic [35:0] v;
    v = {4'b0, acc} * 36'd10 + 36'(d);
    if (acc > SAT_MAX || v > 36'(SAT_MAX)) return SAT_MAX;
    return v[31:0];
  endfunction

  task automatic load_dflt();
    acc_year   = 32'(dflt_year);
    acc_month  = 32'(dflt_month);
    acc_day    = 32'(dflt_day);
    acc_hour   = 32'(dflt_hour);
    acc_minute = 32'(dflt_minute);
    acc_second = 32'(dflt_second);
    acc_zone   = dflt_zone;
  endtask

  // MM-DD was first taken as YYYY-MM: move the fields down
  task automatic shift_date();
    acc_day   = acc_month;
    acc_month = acc_year;
    acc_year  = 32'(dflt_year);
  endtask

  task automatic write_dflt(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    case (idx)
      CFG_YEAR:   dflt_year   = val;
      CFG_MONTH:  dflt_month  = val;
      CFG_DAY:    dflt_day    = val;
      CFG_HOUR:   dflt_hour   = val;
      CFG_MINUTE: dflt_minute = val;
      CFG_SECOND: dflt_second = val;
      CFG_ZONE:   dflt_zone   = val[ZONE_W-1:0];
      default:    ;
    endcase
  endtask

  // Advance the parser model by one accepted byte
  task automatic parse_char(input logic [BYTE_W-1:0] c);
    logic [ST_W-1:0] st;
    logic [3:0]      dg;
    logic            good, is_dig, is_ws, is_sep, is_zone;
    res_t            r;
    st      = pstate;
    dg      = 4'(c - CH_ZERO);
    is_dig  = (c >= CH_ZERO && c <= CH_NINE);
    is_ws   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    is_sep  = (c == CH_UT) || (c == CH_LT) || (c == CH_SPACE) || (c == CH_COMMA);
    is_zone = (c == CH_UZ) || (c == CH_LZ);
    if (st == ST_IDLE) load_dflt();
    if (c == CH_NUL) begin
      good = (st == ST_MONTH) || (st >= ST_DAY && st <= ST_END);
      if (st == ST_MONTH) shift_date();
      if (!good) load_dflt();
      r.ok     = good;
      r.year   = acc_year[VAL_W-1:0];
      r.month  = acc_month[VAL_W-1:0];
      r.day    = acc_day[VAL_W-1:0];
      r.hour   = acc_hour[VAL_W-1:0];
      r.minute = acc_minute[VAL_W-1:0];
      r.second = acc_second[VAL_W-1:0];
      r.zone   = acc_zone;
      stamp_q.push_back(r);
      pstate = ST_IDLE;
      load_dflt();
    end else begin
      case (st)
        ST_IDLE: begin
          if (is_dig) begin
            acc_year = 32'(dg);
            st = ST_YEAR;
          end else if (!is_ws) st = ST_ERROR;
        end
        ST_YEAR: begin
          if (is_dig) acc_year = dec_step(acc_year, dg);
          else if (c == CH_DASH) begin
            acc_month = '0;
            st = ST_MONTH;
          end else if (c == CH_COLON) begin
            acc_hour   = acc_year;
            acc_year   = 32'(dflt_year);
            acc_minute = '0;
            acc_second = '0;
            st = ST_MINUTE;
          end else st = ST_ERROR;
        end
        ST_MONTH: begin
          if (is_dig) acc_month = dec_step(acc_month, dg);
          else if (c == CH_DASH) begin
            acc_day = '0;
            st = ST_DAY;
          end else if (is_sep) begin
            shift_date();
            acc_hour   = '0;
            acc_minute = '0;
            acc_second = '0;
            st = ST_HOUR;
          end else if (is_zone) begin
            acc_zone = c;
            shift_date();
            st = ST_END;
          end else st = ST_ERROR;
        end
        ST_DAY: begin
          if (is_dig) acc_day = dec_step(acc_day, dg);
          else if (is_sep) begin
            acc_hour   = '0;
            acc_minute = '0;
            acc_second = '0;
            st = ST_HOUR;
          end else st = ST_ERROR;
        end
        ST_HOUR: begin
          if (is_dig) acc_hour = dec_step(acc_hour, dg);
          else if (c == CH_COLON) st = ST_MINUTE;
          else if (is_zone) begin
            acc_zone = c;
            st = ST_END;
          end else st = ST_ERROR;
        end
        ST_MINUTE: begin
          if (is_dig) acc_minute = dec_step(acc_minute, dg);
          else if (c == CH_COLON) st = ST_SECOND;
          else if (is_zone) begin
            acc_zone = c;
            st = ST_END;
          end else st = ST_ERROR;
        end
        ST_SECOND: begin
          if (is_dig) acc_second = dec_step(acc_second, dg);
          else if (is_zone) begin
            acc_zone = c;
            st = ST_END;
          end else st = ST_ERROR;
        end
        ST_END: ;
        default: st = ST_ERROR;
      endcase
      pstate = st;
    end
  endtask

  // Feed queue builders
  task automatic add_byte(input logic [BYTE_W-1:0] b);
    feed_t f;
    f = '{kind: F_BYTE, chr: b, idx: '0, val: '0, mode: IM_FREE};
    char_feed_q.push_back(f);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    add_byte(CH_NUL);
  endtask

  task automatic add_cfg(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    feed_t f;
    f = '{kind: F_CFG, chr: '0, idx: idx, val: val, mode: IM_FREE};
    char_feed_q.push_back(f);
  endtask

  task automatic add_ctl(input feed_kind_e k, input idle_mode_e m);
    feed_t f;
    f = '{kind: k, chr: '0, idx: '0, val: '0, mode: m};
    char_feed_q.push_back(f);
  endtask

  task automatic draft_digits(input int n);
    for (int i = 0; i < n; i++) draft_q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Mostly short fields, now and then long enough to saturate
  function automatic int field_len(int min_n);
    if ($urandom_range(99) < 8) return $urandom_range(7, 5);
    return $urandom_range(4, min_n);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_sep();
    case ($urandom_range(3))
      0:       return CH_UT;
      1:       return CH_LT;
      2:       return CH_SPACE;
      default: return CH_COMMA;
    endcase
  endfunction

  // Build one random string into the draft and queue it with its terminator
  task automatic add_random_stamp(output int n);
    int r, form, pos;
    logic [BYTE_W-1:0] w;
    draft_q.delete();
    r = $urandom_range(99);
    if (r < 12) begin
      // noise
      repeat ($urandom_range(8, 1)) draft_q.push_back(8'($urandom_range(255, 1)));
    end else begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(2, 1)) begin
          w = 8'($urandom_range(CH_CR, CH_TAB - 1));
          draft_q.push_back((w < CH_TAB) ? CH_SPACE : w);
        end
      end
      form = $urandom_range(3);
      draft_digits(field_len(1));
      if (form == 3) begin
        // HH:MM[:SS]
        draft_q.push_back(CH_COLON);
        draft_digits(field_len(0));
        if ($urandom_range(1)) begin
          draft_q.push_back(CH_COLON);
          draft_digits(field_len(0));
        end
      end else if (form != 2) begin
        draft_q.push_back(CH_DASH);
        draft_digits(field_len(0));
        if (form == 0) begin
          draft_q.push_back(CH_DASH);
          draft_digits(field_len(0));
        end
        if ($urandom_range(99) < 60) begin
          draft_q.push_back(pick_sep());
          draft_digits(field_len(0));
          if ($urandom_range(99) < 70) begin
            draft_q.push_back(CH_COLON);
            draft_digits(field_len(0));
            if ($urandom_range(1)) begin
              draft_q.push_back(CH_COLON);
              draft_digits(field_len(0));
            end
          end
        end
      end
      if ($urandom_range(99) < 30) begin
        draft_q.push_back($urandom_range(1) ? CH_UZ : CH_LZ);
        repeat ($urandom_range(3)) draft_q.push_back(8'($urandom_range(255, 1)));
      end
      // break some of them at a random spot
      if (r < 25) begin
        pos = $urandom_range(draft_q.size() - 1);
        draft_q[pos] = 8'($urandom_range(255, 1));
      end
    end
    foreach (draft_q[i]) add_byte(draft_q[i]);
    add_byte(CH_NUL);
    n = draft_q.size() + 1;
  endtask

  // Drive bytes and register writes from the feed queue
  always @(posedge clk_i) begin : drv
    logic  nxt_push, nxt_cfg, quiet;
    feed_t head;
    if (rst_ni) begin
      nxt_push = push;
      nxt_cfg  = cfg_valid_i;
      quiet    = (stamp_q.size() == 0) && (quiet_cnt >= SETTLE_CYCLES);
      if (push && !full) begin
        parse_char(text_byte_i);
        head = char_feed_q.pop_front();
        nxt_push = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_dflt(cfg_index_i, cfg_data_i);
        head = char_feed_q.pop_front();
        nxt_cfg = 1'b0;
      end
      if (!nxt_push && !nxt_cfg && char_feed_q.size() != 0) begin
        head = char_feed_q[0];
        case (head.kind)
          F_BYTE: begin
            if ($urandom_range(99) >= tx_idle_pct(mode)) begin
              nxt_push = 1'b1;
              text_byte_i <= head.chr;
            end
          end
          F_CFG: begin
            if (quiet) begin
              nxt_cfg = 1'b1;
              cfg_index_i <= head.idx;
              cfg_data_i  <= head.val;
            end
          end
          F_DRAIN: begin
            if (quiet) head = char_feed_q.pop_front();
          end
          F_MODE: begin
            mode <= head.mode;
            head = char_feed_q.pop_front();
          end
          default: begin
            hold_req <= ~hold_req;
            head = char_feed_q.pop_front();
          end
        endcase
      end
      push        <= nxt_push;
      cfg_valid_i <= nxt_cfg;
      if (stamp_q.size() != 0 || nxt_push) quiet_cnt <= 0;
      else if (quiet_cnt < SETTLE_CYCLES) quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt  <= HOLD_CYCLES;
    end else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Pop result words and compare against the oldest prediction
  always @(posedge clk_i) begin : mon
    res_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = {ok_o, year_o, month_o, day_o, hour_o, minute_o, second_o, zone_char_o};
        if (stamp_q.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("%0t: result word with nothing expected: ok=%0d %0d-%0d-%0d %0d:%0d:%0d z=%02h",
                     $realtime, got.ok, got.year, got.month, got.day, got.hour, got.minute,
                     got.second, got.zone);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = stamp_q.pop_front();
          if (got.ok !== want.ok || got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second ||
              got.zone !== want.zone) begin
            if (fail_cnt < MAX_REPORTS) begin
              $display("%0t: mismatch exp ok=%0d %0d-%0d-%0d %0d:%0d:%0d z=%02h", $realtime,
                       want.ok, want.year, want.month, want.day, want.hour, want.minute,
                       want.second, want.zone);
              $display("%0t:          got ok=%0d %0d-%0d-%0d %0d:%0d:%0d z=%02h", $realtime,
                       got.ok, got.year, got.month, got.day, got.hour, got.minute,
                       got.second, got.zone);
            end
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      pop <= (hold_cnt == 0) && ($urandom_range(99) >= rx_idle_pct(mode));
    end
  end

  // Stimulus, reset and end of run
  initial begin : stim
    int n, seg_bytes;
    logic [VAL_W-1:0] v;
    add_ctl(F_MODE, IM_RX_SLOW);

    // Directed strings at reset defaults
    add_text("2024-03-15T12:34:56Z");
    add_text("2024-03-15t01:02:03z");
    add_text("12:30");
    add_text("12:30:45");
    add_text("03-15");
    add_text("03-15Z");
    add_text("03-15 08:09");
    add_text("2024-03-15,7");
    add_text("2024");
    add_text("");
    add_byte(CH_TAB);
    add_byte(CH_LF);
    add_byte(CH_VT);
    add_byte(CH_FF);
    add_byte(CH_CR);
    add_text(" 7-8");
    add_text("99999999-1-1T4:5:99999999");
    add_text("12:30zjunk");
    add_byte(8'hFF);
    add_text("12");
    add_byte(8'h80);
    add_byte(CH_NUL);
    add_text("2024-03-15T12x34");
    add_text("2024:");
    add_text("1-2-3 ");
    add_text("1-2-");
    add_text("12:3:4:5");
    add_text("1-2x");

    // Phases of register settings: zero, all ones, then random
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) add_ctl(F_MODE, IM_TX_SLOW);
      if (seg == 4) begin
        add_ctl(F_MODE, IM_FREE);
        add_ctl(F_RXHOLD, IM_FREE);
      end
      for (int r = 0; r < 7; r++) begin
        if (seg == 0) v = '0;
        else if (seg == 1) v = '1;
        else v = VAL_W'($urandom_range(65535));
        add_cfg(CIDX_W'(r), v);
      end
      if (seg == 0) add_cfg(CIDX_W'(7), VAL_W'($urandom_range(65535)));
      if (seg == 3) add_cfg(CFG_ZONE, {8'($urandom_range(255)), CH_UZ});
      seg_bytes = 0;
      while (seg_bytes < SEG_BYTES) begin
        add_random_stamp(n);
        seg_bytes += n;
        if ($urandom_range(99) < 5) add_ctl(F_DRAIN, IM_FREE);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain everything, then let the pipeline settle
    while (char_feed_q.size() != 0 || push || cfg_valid_i) @(posedge clk_i);
    while (stamp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("iso_date_time_text_parser_top regression: pass");
    end else begin
      $display("iso_date_time_text_parser_top regression: fail");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #400000;
    $display("iso_date_time_text_parser_top regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
design/dtp_pkg.sv
design/dtp_front.sv
design/dtp_back.sv
design/iso_date_time_text_parser_top.sv
bench/tb.sv
